// ===== rtl/core/scld_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the serial command line decoder.
// No dependencies; the line parser and the top level refer to this package.
package scld_pkg;

   // Default line size in bytes: one header plus up to MESSAGE_BYTES-1 body bytes
   localparam int MESSAGE_BYTES_DEFAULT = 64;

   // Configuration port
   localparam int CSR_DATA_W = 16;
   localparam logic CSR_END_CHAR = 1'b0;
   localparam logic CSR_TIMEOUT = 1'b1;
   localparam logic [7:0] END_CHAR_RESET = 8'd10;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   // Message kinds reported on the result channel
   localparam logic [2:0] KIND_DRIVE = 3'd0;
   localparam logic [2:0] KIND_LIGHT = 3'd1;
   localparam logic [2:0] KIND_INDICATOR = 3'd2;
   localparam logic [2:0] KIND_HEARTBEAT = 3'd3;
   localparam logic [2:0] KIND_NOTIFY = 3'd4;
   localparam logic [2:0] KIND_FEATURE = 3'd5;
   localparam logic [2:0] KIND_VOLTAGE = 3'd6;
   localparam logic [2:0] KIND_NONE = 3'd7;

   // Request types
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // Header characters
   localparam logic [7:0] HDR_DRIVE = 8'h63;      // 'c'
   localparam logic [7:0] HDR_LIGHT = 8'h6C;      // 'l'
   localparam logic [7:0] HDR_INDICATOR = 8'h69;  // 'i'
   localparam logic [7:0] HDR_HEARTBEAT = 8'h68;  // 'h'
   localparam logic [7:0] HDR_NOTIFY = 8'h6E;     // 'n'
   localparam logic [7:0] HDR_FEATURE = 8'h66;    // 'f'
   localparam logic [7:0] HDR_VOLTAGE = 8'h76;    // 'v'

   // Body characters
   localparam logic [7:0] CHR_NUL = 8'h00;
   localparam logic [7:0] CHR_COMMA = 8'h2C;
   localparam logic [7:0] CHR_COLON = 8'h3A;
   localparam logic [7:0] CHR_PLUS = 8'h2B;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_TAB = 8'h09;
   localparam logic [7:0] CHR_CR = 8'h0D;
   localparam logic [7:0] CHR_ZERO = 8'h30;
   localparam logic [7:0] CHR_NINE = 8'h39;

   // Decoded line content handed from the parser to the top level
   typedef struct packed {
      logic [2:0] kind;
      logic [15:0] first_value;
      logic [15:0] second_value;
      logic [7:0] led_code;
      logic [31:0] heartbeat_interval;
   } line_result_type;

endpackage

// ===== rtl/core/scld_channels.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and result sides.
// Depends on nothing; used by the top level and its environment.

interface scld_req_if;
   logic valid;
   logic ready;
   logic req_type;
   logic [7:0] data_byte;

   modport source(output valid, output req_type, output data_byte, input ready);
   modport sink(input valid, input req_type, input data_byte, output ready);
endinterface

interface scld_rsp_if;
   logic valid;
   logic ready;
   logic [2:0] msg_kind;
   logic signed [15:0] first_value;
   logic signed [15:0] second_value;
   logic [7:0] led_code;
   logic [31:0] heartbeat_interval;
   logic link_up;

   modport source(output valid, output msg_kind, output first_value, output second_value,
                  output led_code, output heartbeat_interval, output link_up, input ready);
   modport sink(input valid, input msg_kind, input first_value, input second_value,
                input led_code, input heartbeat_interval, input link_up, output ready);
endinterface

// ===== rtl/core/scld_line_parser.sv =====
`timescale 1ns / 1ps
// Line parser: header capture, on-the-fly field and heartbeat number decode.
// Depends on scld_pkg.
module scld_line_parser #(
   parameter int MESSAGE_BYTES = scld_pkg::MESSAGE_BYTES_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic advance,
   input logic req_type,
   input logic [7:0] data_byte,
   input logic [7:0] end_char,
   output scld_pkg::line_result_type result
);

   localparam int LEN_W = $clog2(MESSAGE_BYTES);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MESSAGE_BYTES - 1);
   localparam logic [16:0] MAG_CAP = 17'd32768;

   typedef enum logic [4:0] {
      FIELD_LEAD = 5'b00001,
      FIELD_FIRST = 5'b00010,
      FIELD_GAP = 5'b00100,
      FIELD_SECOND = 5'b01000,
      FIELD_AFTER = 5'b10000
   } field_stage_type;

   typedef enum logic [2:0] {
      NUM_SPACE = 3'b001,
      NUM_DIGITS = 3'b010,
      NUM_DONE = 3'b100
   } num_stage_type;

   typedef enum logic [2:0] {
      CLS_SPACE,
      CLS_PLUS,
      CLS_MINUS,
      CLS_DIGIT,
      CLS_OTHER
   } char_class_type;

   function automatic char_class_type classify(input logic [7:0] c);
      char_class_type cls;
      if (c == scld_pkg::CHR_SPACE || (c >= scld_pkg::CHR_TAB && c <= scld_pkg::CHR_CR))
         cls = CLS_SPACE;
      else if (c == scld_pkg::CHR_PLUS)
         cls = CLS_PLUS;
      else if (c == scld_pkg::CHR_MINUS)
         cls = CLS_MINUS;
      else if (c >= scld_pkg::CHR_ZERO && c <= scld_pkg::CHR_NINE)
         cls = CLS_DIGIT;
      else
         cls = CLS_OTHER;
      return cls;
   endfunction

   // magnitude plus sign to 16-bit two's complement, positive side clipped
   function automatic logic [15:0] to_signed16(input logic [16:0] mag, input logic neg);
      logic [16:0] negated;
      logic [15:0] value;
      negated = 17'd0 - mag;
      if (neg)
         value = negated[15:0];
      else if (mag > 17'd32767)
         value = 16'h7FFF;
      else
         value = mag[15:0];
      return value;
   endfunction

   // line state
   logic in_body_ff, in_body_in;
   logic [7:0] header_ff, header_in;
   logic [LEN_W-1:0] body_len_ff, body_len_in;
   logic terminated_ff, terminated_in;
   field_stage_type field_ff, field_in;
   num_stage_type number_ff, number_in;
   logic [16:0] first_acc_ff, first_acc_in;
   logic [16:0] second_acc_ff, second_acc_in;
   logic first_neg_ff, first_neg_in;
   logic second_neg_ff, second_neg_in;
   logic [7:0] led_ff, led_in;
   logic [31:0] whole_acc_ff, whole_acc_in;
   num_stage_type whole_ff, whole_in;
   logic whole_neg_ff, whole_neg_in;

   logic is_byte, is_end, is_delim, on_first;
   char_class_type cls;
   logic [3:0] digit;

   // field number feeder
   num_stage_type num_stage_eff, num_stage_nx;
   logic [16:0] num_acc_cur, num_acc_nx;
   logic [19:0] num_prod;
   logic num_neg_set;

   // heartbeat number feeder
   num_stage_type whole_stage_nx;
   logic [31:0] whole_acc_nx;
   logic whole_neg_nx;

   assign is_byte = (req_type == scld_pkg::REQ_BYTE);
   assign is_end = is_byte && (data_byte == end_char);
   assign is_delim = (data_byte == scld_pkg::CHR_COMMA) || (data_byte == scld_pkg::CHR_COLON);
   assign cls = classify(data_byte);
   assign digit = data_byte[3:0];
   assign on_first = (field_ff == FIELD_LEAD) || (field_ff == FIELD_FIRST);

   // a new field starts its number from whitespace skipping
   assign num_stage_eff = ((field_ff == FIELD_LEAD) || (field_ff == FIELD_GAP)) ? NUM_SPACE
                                                                              : number_ff;
   assign num_acc_cur = on_first ? first_acc_ff : second_acc_ff;
   assign num_prod = {num_acc_cur, 3'b000} + {2'b00, num_acc_cur, 1'b0} + {16'd0, digit};

   // atoi-style step for one field, magnitude held at the cap
   always_comb begin
      num_stage_nx = num_stage_eff;
      num_acc_nx = num_acc_cur;
      num_neg_set = 1'b0;
      unique case (num_stage_eff)
         NUM_SPACE: begin
            case (cls)
               CLS_SPACE: ;
               CLS_PLUS: num_stage_nx = NUM_DIGITS;
               CLS_MINUS: begin
                  num_neg_set = 1'b1;
                  num_stage_nx = NUM_DIGITS;
               end
               CLS_DIGIT: begin
                  num_acc_nx = {13'd0, digit};
                  num_stage_nx = NUM_DIGITS;
               end
               default: num_stage_nx = NUM_DONE;
            endcase
         end
         NUM_DIGITS: begin
            if (cls == CLS_DIGIT)
               num_acc_nx = (num_prod > {3'b000, MAG_CAP}) ? MAG_CAP : num_prod[16:0];
            else
               num_stage_nx = NUM_DONE;
         end
         NUM_DONE: ;
         default: ;
      endcase
   end

   // atoi-style step for the heartbeat value, wrapping at 32 bits
   always_comb begin
      whole_stage_nx = whole_ff;
      whole_acc_nx = whole_acc_ff;
      whole_neg_nx = whole_neg_ff;
      unique case (whole_ff)
         NUM_SPACE: begin
            case (cls)
               CLS_SPACE: ;
               CLS_PLUS: whole_stage_nx = NUM_DIGITS;
               CLS_MINUS: begin
                  whole_neg_nx = 1'b1;
                  whole_stage_nx = NUM_DIGITS;
               end
               CLS_DIGIT: begin
                  whole_acc_nx = {28'd0, digit};
                  whole_stage_nx = NUM_DIGITS;
               end
               default: whole_stage_nx = NUM_DONE;
            endcase
         end
         NUM_DIGITS: begin
            if (cls == CLS_DIGIT)
               whole_acc_nx = {whole_acc_ff[28:0], 3'b000} + {whole_acc_ff[30:0], 1'b0}
                              + {28'd0, digit};
            else
               whole_stage_nx = NUM_DONE;
         end
         NUM_DONE: ;
         default: ;
      endcase
   end

   // next line state
   always_comb begin
      in_body_in = in_body_ff;
      header_in = header_ff;
      body_len_in = body_len_ff;
      terminated_in = terminated_ff;
      field_in = field_ff;
      number_in = number_ff;
      first_acc_in = first_acc_ff;
      second_acc_in = second_acc_ff;
      first_neg_in = first_neg_ff;
      second_neg_in = second_neg_ff;
      led_in = led_ff;
      whole_acc_in = whole_acc_ff;
      whole_in = whole_ff;
      whole_neg_in = whole_neg_ff;
      if (advance && is_byte) begin
         if (is_end) begin
            in_body_in = 1'b0;
            header_in = 8'd0;
            body_len_in = '0;
            terminated_in = 1'b0;
            field_in = FIELD_LEAD;
            number_in = NUM_SPACE;
            first_acc_in = 17'd0;
            second_acc_in = 17'd0;
            first_neg_in = 1'b0;
            second_neg_in = 1'b0;
            led_in = 8'd0;
            whole_acc_in = 32'd0;
            whole_in = NUM_SPACE;
            whole_neg_in = 1'b0;
         end else if (!in_body_ff) begin
            header_in = data_byte;
            in_body_in = 1'b1;
         end else if (body_len_ff < LEN_MAX) begin
            body_len_in = body_len_ff + LEN_W'(1);
            if (!terminated_ff) begin
               if (data_byte == scld_pkg::CHR_NUL) begin
                  terminated_in = 1'b1;
               end else begin
                  whole_acc_in = whole_acc_nx;
                  whole_in = whole_stage_nx;
                  whole_neg_in = whole_neg_nx;
                  if (is_delim) begin
                     if (field_ff == FIELD_FIRST)
                        field_in = FIELD_GAP;
                     else if (field_ff == FIELD_SECOND)
                        field_in = FIELD_AFTER;
                  end else if (field_ff != FIELD_AFTER) begin
                     number_in = num_stage_nx;
                     if (field_ff == FIELD_LEAD) begin
                        field_in = FIELD_FIRST;
                        led_in = data_byte;
                     end else if (field_ff == FIELD_GAP) begin
                        field_in = FIELD_SECOND;
                     end
                     if (on_first) begin
                        first_acc_in = num_acc_nx;
                        first_neg_in = first_neg_ff | num_neg_set;
                     end else begin
                        second_acc_in = num_acc_nx;
                        second_neg_in = second_neg_ff | num_neg_set;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff <= 1'b0;
         header_ff <= 8'd0;
         body_len_ff <= '0;
         terminated_ff <= 1'b0;
         field_ff <= FIELD_LEAD;
         number_ff <= NUM_SPACE;
         first_acc_ff <= 17'd0;
         second_acc_ff <= 17'd0;
         first_neg_ff <= 1'b0;
         second_neg_ff <= 1'b0;
         led_ff <= 8'd0;
         whole_acc_ff <= 32'd0;
         whole_ff <= NUM_SPACE;
         whole_neg_ff <= 1'b0;
      end else begin
         in_body_ff <= in_body_in;
         header_ff <= header_in;
         body_len_ff <= body_len_in;
         terminated_ff <= terminated_in;
         field_ff <= field_in;
         number_ff <= number_in;
         first_acc_ff <= first_acc_in;
         second_acc_ff <= second_acc_in;
         first_neg_ff <= first_neg_in;
         second_neg_ff <= second_neg_in;
         led_ff <= led_in;
         whole_acc_ff <= whole_acc_in;
         whole_ff <= whole_in;
         whole_neg_ff <= whole_neg_in;
      end
   end

   // message decode at the end character, from the state before this byte
   logic two_fields;
   assign two_fields = (field_ff == FIELD_SECOND) || (field_ff == FIELD_AFTER);

   always_comb begin
      result = '0;
      result.kind = scld_pkg::KIND_NONE;
      if (is_end) begin
         case (header_ff)
            scld_pkg::HDR_DRIVE, scld_pkg::HDR_LIGHT, scld_pkg::HDR_INDICATOR: begin
               if (two_fields) begin
                  if (header_ff == scld_pkg::HDR_DRIVE)
                     result.kind = scld_pkg::KIND_DRIVE;
                  else if (header_ff == scld_pkg::HDR_LIGHT)
                     result.kind = scld_pkg::KIND_LIGHT;
                  else
                     result.kind = scld_pkg::KIND_INDICATOR;
                  result.first_value = to_signed16(first_acc_ff, first_neg_ff);
                  result.second_value = to_signed16(second_acc_ff, second_neg_ff);
               end
            end
            scld_pkg::HDR_NOTIFY: begin
               if (two_fields) begin
                  result.kind = scld_pkg::KIND_NOTIFY;
                  result.led_code = led_ff;
                  result.second_value = to_signed16(second_acc_ff, second_neg_ff);
               end
            end
            scld_pkg::HDR_HEARTBEAT: begin
               result.kind = scld_pkg::KIND_HEARTBEAT;
               result.heartbeat_interval = whole_neg_ff ? (32'd0 - whole_acc_ff) : whole_acc_ff;
            end
            scld_pkg::HDR_FEATURE: result.kind = scld_pkg::KIND_FEATURE;
            scld_pkg::HDR_VOLTAGE: result.kind = scld_pkg::KIND_VOLTAGE;
            default: ;
         endcase
      end
   end

endmodule

// ===== rtl/core/scld_link_timer.sv =====
`timescale 1ns / 1ps
// Heartbeat age counter and link status compare.
// Depends on nothing outside this file.
module scld_link_timer (
   input logic clock,
   input logic reset,
   input logic advance,
   input logic tick,
   input logic heartbeat,
   input logic [15:0] timeout,
   output logic link_up_next
);

   logic [15:0] age_ff, age_in;

   // age saturates at all ones; a heartbeat line restarts it
   always_comb begin
      age_in = age_ff;
      if (advance) begin
         if (tick) begin
            if (age_ff != 16'hFFFF)
               age_in = age_ff + 16'd1;
         end else if (heartbeat) begin
            age_in = 16'd0;
         end
      end
   end

   // status reported with this transaction uses the updated age
   assign link_up_next = (age_in < timeout);

   always_ff @(posedge clock) begin
      if (reset)
         age_ff <= 16'd0;
      else
         age_ff <= age_in;
   end

endmodule

// ===== rtl/core/serial_command_line_decoder_top.sv =====
`timescale 1ns / 1ps
// Top level of the serial command line decoder: config registers and result register.
// Depends on scld_pkg, scld_channels, scld_line_parser and scld_link_timer.
//
// Usage:
//   req_chan carries one transaction per received serial byte (req_type 0) or per
//   elapsed millisecond (req_type 1). Every accepted request yields exactly one
//   transaction on rsp_chan, in order: a decoded message at the end character,
//   msg_kind none otherwise, and always the current link status.
//   The result is registered in the output register on the clock edge that accepts
//   the request. Throughput is one request per cycle while rsp_chan takes results;
//   the parser and the age counter update in the same cycle the request is accepted.
//   req_chan.ready is high whenever the output register is empty or is being
//   emptied, so a stalled receiver holds back at most one result and then the
//   request side waits.
//   csr_write_enable writes csr_write_data to register csr_index (0 end character,
//   1 heartbeat timeout in ms); write only while no transaction is in flight.
//   Synchronous reset restores end character 10 and timeout 1000, clears line
//   state and heartbeat age, and empties the output register.
module serial_command_line_decoder_top #(
   parameter int MESSAGE_BYTES = scld_pkg::MESSAGE_BYTES_DEFAULT
) (
   input logic clock,
   input logic reset,
   scld_req_if.sink req_chan,
   scld_rsp_if.source rsp_chan,
   input logic csr_write_enable,
   input logic csr_index,
   input logic [scld_pkg::CSR_DATA_W-1:0] csr_write_data
);

   // configuration registers
   logic [7:0] end_char_ff, end_char_in;
   logic [15:0] timeout_ff, timeout_in;

   always_comb begin
      end_char_in = end_char_ff;
      timeout_in = timeout_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            scld_pkg::CSR_END_CHAR: end_char_in = csr_write_data[7:0];
            scld_pkg::CSR_TIMEOUT: timeout_in = csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         end_char_ff <= scld_pkg::END_CHAR_RESET;
         timeout_ff <= scld_pkg::TIMEOUT_RESET;
      end else begin
         end_char_ff <= end_char_in;
         timeout_ff <= timeout_in;
      end
   end

   // handshake: take a request whenever the output register can be refilled
   logic rsp_valid_ff;
   logic advance;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign advance = req_chan.valid && req_chan.ready;

   scld_pkg::line_result_type line_result;
   logic link_up_next;

   scld_line_parser #(
      .MESSAGE_BYTES(MESSAGE_BYTES)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .req_type(req_chan.req_type),
      .data_byte(req_chan.data_byte),
      .end_char(end_char_ff),
      .result(line_result)
   );

   scld_link_timer u_timer (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .tick(req_chan.req_type == scld_pkg::REQ_TICK),
      .heartbeat(line_result.kind == scld_pkg::KIND_HEARTBEAT),
      .timeout(timeout_ff),
      .link_up_next(link_up_next)
   );

   // output register
   logic rsp_valid_in;
   logic [2:0] rsp_kind_ff;
   logic [15:0] rsp_first_ff, rsp_second_ff;
   logic [7:0] rsp_led_ff;
   logic [31:0] rsp_interval_ff;
   logic rsp_link_ff;

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_kind_ff <= line_result.kind;
         rsp_first_ff <= line_result.first_value;
         rsp_second_ff <= line_result.second_value;
         rsp_led_ff <= line_result.led_code;
         rsp_interval_ff <= line_result.heartbeat_interval;
         rsp_link_ff <= link_up_next;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.msg_kind = rsp_kind_ff;
   assign rsp_chan.first_value = rsp_first_ff;
   assign rsp_chan.second_value = rsp_second_ff;
   assign rsp_chan.led_code = rsp_led_ff;
   assign rsp_chan.heartbeat_interval = rsp_interval_ff;
   assign rsp_chan.link_up = rsp_link_ff;

`ifndef NO_ASSERTIONS
   // an accepted request always leaves a result behind
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

   // a millisecond tick never decodes a message
   a_tick_no_msg: assert property (@(posedge clock) disable iff (reset)
      (advance && req_chan.req_type == scld_pkg::REQ_TICK)
      |=> (rsp_kind_ff == scld_pkg::KIND_NONE))
      else $error("tick transaction reported a message");

   // a heartbeat brings the link up unless the timeout is zero
   a_heartbeat_link: assert property (@(posedge clock) disable iff (reset)
      (advance && line_result.kind == scld_pkg::KIND_HEARTBEAT && timeout_ff != 16'd0)
      |=> rsp_link_ff)
      else $error("heartbeat did not bring the link up");

   // results without a message carry all-zero payload
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == scld_pkg::KIND_NONE)
      |-> (rsp_first_ff == 16'd0 && rsp_second_ff == 16'd0 && rsp_led_ff == 8'd0
           && rsp_interval_ff == 32'd0))
      else $error("empty result carries payload");
`endif

endmodule
